// ===== rtl/i2a_pkg.sv =====
// types, codes and character constants shared by the integer to ascii digits block
package i2a_pkg;

   localparam logic [1:0] OP_UNSIGNED = 2'd0;
   localparam logic [1:0] OP_SIGNED   = 2'd1;
   localparam logic [1:0] OP_HEX      = 2'd2;

   localparam logic [6:0] CHAR_ZERO         = 7'd48;
   localparam logic [6:0] CHAR_MINUS        = 7'd45;
   localparam logic [6:0] HEX_LETTER_OFFSET = 7'd55;

   localparam int unsigned DEC_DIGITS = 20;
   localparam int unsigned HEX_DIGITS = 16;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] value;
      logic [3:0]  hex_bytes;
   } req_payload_type;

   typedef struct packed {
      logic [6:0] character;
      logic       last;
   } rsp_payload_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] wide;
      wide = {3'b000, nib};
      if (nib > 4'd9) begin
         hex_char = wide + HEX_LETTER_OFFSET;
      end else begin
         hex_char = wide + CHAR_ZERO;
      end
   endfunction

endpackage

// ===== rtl/integer_to_ascii_digits.sv =====
// top level: converts a 64-bit value to ascii decimal or hexadecimal characters
//
// one number enters on the req_ channel as a beat of operation, value and
// hex_bytes; the block answers with one rsp_ beat per character, most
// significant first, with last set on the final character. operation 3 is
// taken and gives no characters.
// decimal modes run a bit-serial double dabble over 20 bcd digits, one
// value bit per cycle, then send a minus sign when negative, then drop
// leading zeros one digit per cycle and send one digit per cycle unless
// rsp_stall holds the output. hex mode skips the unused high nibbles one
// per cycle and sends 2 to 16 nibbles one per cycle unless rsp_stall
// holds the output.
// req_stall is high from the accepted beat until the last character has
// been loaded into the output register; the next number is taken while
// that character still waits. rsp_stall holds the output register and
// pauses the sending of the sign and digits; nothing is lost.
// a synchronous reset returns the sequencer to idle and empties the output.
module integer_to_ascii_digits
   import i2a_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SIGN = 3'd2;
   localparam logic [2:0] ST_SKIP = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   localparam int unsigned DIG_W = 4 * DEC_DIGITS;

   logic [2:0]       state_ff, state_in;
   logic [63:0]      mag_ff, mag_in;
   logic [DIG_W-1:0] dig_ff, dig_in;
   logic [5:0]       bit_cnt_ff, bit_cnt_in;
   logic [4:0]       rem_ff, rem_in;
   logic [4:0]       nib_lim_ff, nib_lim_in;
   logic             hex_ff, hex_in;
   logic             neg_ff, neg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;

   logic             req_take;
   logic             out_free;
   logic [3:0]       top_digit;
   logic             skip_now;
   logic [DIG_W-1:0] dig_adj;
   logic [3:0]       nbytes;
   logic [63:0]      req_mag;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign top_digit   = dig_ff[DIG_W-1 -: 4];
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign skip_now = hex_ff ? (rem_ff > nib_lim_ff)
                            : ((top_digit == 4'd0) && (rem_ff > 5'd1));

   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (dig_ff[4*i +: 4] >= 4'd5) begin
            dig_adj[4*i +: 4] = dig_ff[4*i +: 4] + 4'd3;
         end else begin
            dig_adj[4*i +: 4] = dig_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      if (req_payload.hex_bytes == 4'd0) begin
         nbytes = 4'd1;
      end else if (req_payload.hex_bytes > 4'd8) begin
         nbytes = 4'd8;
      end else begin
         nbytes = req_payload.hex_bytes;
      end
      if ((req_payload.operation == OP_SIGNED) && req_payload.value[63]) begin
         req_mag = (~req_payload.value) + 64'd1;
      end else begin
         req_mag = req_payload.value;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      dig_in       = dig_ff;
      bit_cnt_in   = bit_cnt_ff;
      rem_in       = rem_ff;
      nib_lim_in   = nib_lim_ff;
      hex_in       = hex_ff;
      neg_in       = neg_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               nib_lim_in = {nbytes, 1'b0};
               neg_in     = (req_payload.operation == OP_SIGNED) && req_payload.value[63];
               mag_in     = req_mag;
               bit_cnt_in = 6'd63;
               case (req_payload.operation)
                  OP_UNSIGNED, OP_SIGNED: begin
                     hex_in   = 1'b0;
                     dig_in   = '0;
                     state_in = ST_CONV;
                  end
                  OP_HEX: begin
                     hex_in   = 1'b1;
                     dig_in   = {req_payload.value, {(DIG_W-64){1'b0}}};
                     rem_in   = 5'(HEX_DIGITS);
                     state_in = ST_SKIP;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CONV: begin
            dig_in     = {dig_adj[DIG_W-2:0], mag_ff[63]};
            mag_in     = {mag_ff[62:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 6'd1;
            if (bit_cnt_ff == 6'd0) begin
               rem_in   = 5'(DEC_DIGITS);
               state_in = neg_ff ? ST_SIGN : ST_SKIP;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.character = CHAR_MINUS;
               rsp_in.last      = 1'b0;
               state_in         = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (skip_now) begin
               dig_in = {dig_ff[DIG_W-5:0], 4'd0};
               rem_in = rem_ff - 5'd1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.character = hex_char(top_digit);
               rsp_in.last      = (rem_ff == 5'd1);
               dig_in           = {dig_ff[DIG_W-5:0], 4'd0};
               rem_in           = rem_ff - 5'd1;
               if (rem_ff == 5'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff     <= mag_in;
      dig_ff     <= dig_in;
      bit_cnt_ff <= bit_cnt_in;
      rem_ff     <= rem_in;
      nib_lim_ff <= nib_lim_in;
      hex_ff     <= hex_in;
      neg_ff     <= neg_in;
      rsp_ff     <= rsp_in;
   end

   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (rem_ff != 5'd0))
      else $error("emit state with no digits left");

   a_bcd_digit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !hex_ff) |-> (top_digit <= 4'd9))
      else $error("decimal digit out of range");

   a_conv_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && bit_cnt_ff == 6'd0)
      |=> (state_ff == ST_SIGN || state_ff == ST_SKIP))
      else $error("conversion did not finish after 64 bits");

   a_last_digit_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP && !hex_ff && rem_ff == 5'd1) |=> (state_ff == ST_EMIT))
      else $error("final decimal digit was skipped");

endmodule

// ===== sim/integer_to_ascii_digits_test.sv =====
// self-checking testbench for the integer to ascii digits block
module integer_to_ascii_digits_test;
   import i2a_pkg::*;

   localparam int unsigned RANDOM_NUMBERS = 380;
   localparam int unsigned LONG_HOLD      = 300;
   localparam int unsigned SETTLE_CYCLES  = 150;
   localparam int unsigned STALL_LIMIT    = 3000;

   class digit_scoreboard;
      rsp_payload_type pending_chars[$];
      logic [6:0]      spelled[$];
      int unsigned     mismatches;
      int unsigned     chars_checked;

      function new();
         mismatches    = 0;
         chars_checked = 0;
      endfunction

      function logic [6:0] hex_digit(input logic [3:0] nib);
         if (nib > 4'd9) begin
            return {3'b000, nib} + HEX_LETTER_OFFSET;
         end
         return {3'b000, nib} + CHAR_ZERO;
      endfunction

      function void decimal_digits(input logic [63:0] mag);
         logic [6:0] reversed[$];
         reversed = {};
         do begin
            reversed.push_front(CHAR_ZERO + 7'(mag % 64'd10));
            mag = mag / 64'd10;
         end while (mag != 64'd0);
         foreach (reversed[i]) spelled.push_back(reversed[i]);
      endfunction

      function void note_number(input req_payload_type beat);
         rsp_payload_type entry;
         logic [3:0]      nbytes;
         logic [7:0]      octet;
         int              b;
         spelled = {};
         case (beat.operation)
            OP_UNSIGNED: begin
               decimal_digits(beat.value);
            end
            OP_SIGNED: begin
               if (beat.value[63]) begin
                  spelled.push_back(CHAR_MINUS);
                  decimal_digits((~beat.value) + 64'd1);
               end else begin
                  decimal_digits(beat.value);
               end
            end
            OP_HEX: begin
               nbytes = beat.hex_bytes;
               if (nbytes == 4'd0) nbytes = 4'd1;
               if (nbytes > 4'd8) nbytes = 4'd8;
               for (b = int'(nbytes) - 1; b >= 0; b--) begin
                  octet = 8'(beat.value >> (b * 8));
                  spelled.push_back(hex_digit(octet[7:4]));
                  spelled.push_back(hex_digit(octet[3:0]));
               end
            end
            default: begin
            end
         endcase
         foreach (spelled[i]) begin
            entry.character = spelled[i];
            entry.last      = (i == spelled.size() - 1);
            pending_chars.push_back(entry);
         end
      endfunction

      function void check_char(input rsp_payload_type got);
         rsp_payload_type want;
         chars_checked++;
         if (pending_chars.size() == 0) begin
            mismatches++;
            $display("%0t unexpected beat: expected none, got char %0d last %0b",
                     $time, got.character, got.last);
            return;
         end
         want = pending_chars.pop_front();
         if (got.character !== want.character) begin
            mismatches++;
            $display("%0t character mismatch: expected %0d, got %0d",
                     $time, want.character, got.character);
         end
         if (got.last !== want.last) begin
            mismatches++;
            $display("%0t last mismatch: expected %0b, got %0b", $time, want.last, got.last);
         end
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;

   digit_scoreboard sb;
   int unsigned     idle_cycles = 0;
   int unsigned     ops_sent[4];
   bit              quiet = 0;
   bit              hold_receiver = 0;

   integer_to_ascii_digits u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #6 clock = ~clock;

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_number(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_char(rsp_payload);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else if (req_valid || sb.pending_chars.size() != 0) begin
            idle_cycles++;
         end
      end
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("%0t watchdog: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // receiver: random stall before each beat, one long hold-off on request
   initial begin
      int unsigned stall_len;
      wait (reset === 1'b0);
      forever begin
         stall_len = quiet ? 0 : $urandom_range(0, 3);
         if (hold_receiver) begin
            hold_receiver = 0;
            stall_len     = LONG_HOLD;
         end
         repeat (stall_len) @(negedge clock) rsp_stall <= 1'b1;
         @(negedge clock) rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   function automatic req_payload_type make_beat(input logic [1:0] op,
                                                 input logic [63:0] value,
                                                 input logic [3:0] nbytes);
      req_payload_type beat;
      beat.operation = op;
      beat.value     = value;
      beat.hex_bytes = nbytes;
      return beat;
   endfunction

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      case ($urandom_range(0, 5))
         0: ;
         1: v = 64'($urandom_range(0, 999));
         2: begin
            v = 64'd1;
            repeat ($urandom_range(0, 19)) v = v * 64'd10;
            v = v + 64'($urandom_range(0, 2)) - 64'd1;
         end
         3: v[63] = 1'b1;
         4: v = ~64'($urandom_range(0, 20));
         default: v = v >> $urandom_range(0, 63);
      endcase
      return v;
   endfunction

   task automatic send_number(input req_payload_type beat);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_payload <= beat;
      req_valid   <= 1'b1;
      ops_sent[beat.operation]++;
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
   endtask

   task automatic pause_sender();
      @(negedge clock) req_valid <= 1'b0;
      while (sb.pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [1:0] op;
      int unsigned r;
      sb          = new();
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: field extremes, each mode and the corner cases
      send_number(make_beat(OP_UNSIGNED, 64'd0, 4'd0));
      send_number(make_beat(OP_UNSIGNED, 64'd9, 4'd0));
      send_number(make_beat(OP_UNSIGNED, 64'd10, 4'd0));
      send_number(make_beat(OP_UNSIGNED, 64'd10000000000000000000, 4'd0));
      send_number(make_beat(OP_UNSIGNED, '1, 4'd15));
      send_number(make_beat(OP_SIGNED, 64'd0, 4'd0));
      send_number(make_beat(OP_SIGNED, '1, 4'd0));
      send_number(make_beat(OP_SIGNED, 64'h8000_0000_0000_0000, 4'd0));
      send_number(make_beat(OP_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, 4'd7));
      send_number(make_beat(OP_SIGNED, -64'sd10, 4'd0));
      send_number(make_beat(OP_HEX, 64'h0123_4567_89AB_CDEF, 4'd8));
      send_number(make_beat(OP_HEX, '1, 4'd8));
      send_number(make_beat(OP_HEX, 64'h0000_0000_0000_00A5, 4'd0));
      send_number(make_beat(OP_HEX, 64'hFEDC_BA98_7654_3210, 4'd1));
      send_number(make_beat(OP_HEX, 64'hFEDC_BA98_7654_3210, 4'd4));
      send_number(make_beat(OP_HEX, 64'h0000_0000_0000_0000, 4'd9));
      send_number(make_beat(OP_HEX, 64'hDEAD_BEEF_CAFE_F00D, 4'd15));
      send_number(make_beat(2'd3, '1, 4'd15));
      send_number(make_beat(2'd3, 64'd0, 4'd0));
      send_number(make_beat(OP_UNSIGNED, 64'd1, 4'd0));

      for (int i = 0; i < RANDOM_NUMBERS; i++) begin
         // long receiver hold-off while numbers keep coming
         if (i == 100) hold_receiver = 1;
         if (i == 200) pause_sender();
         quiet = (i >= 250 && i < 310);
         r = $urandom_range(0, 19);
         if (r < 7) op = OP_UNSIGNED;
         else if (r < 14) op = OP_SIGNED;
         else if (r < 19) op = OP_HEX;
         else op = 2'd3;
         send_number(make_beat(op, random_value(), 4'($urandom_range(0, 15))));
      end
      quiet = 0;
      pause_sender();

      $display("covered %0d unsigned, %0d signed, %0d hex and %0d unused-mode numbers",
               ops_sent[0], ops_sent[1], ops_sent[2], ops_sent[3]);
      $display("checked %0d characters, %0d mismatches", sb.chars_checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_chars.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
